// ===== rtl/ccg_pkg.sv =====
// Core count governor package: beat types, register map, sequencer and action codes.
// Shared by the governor top level and its port checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccg_pkg;

    // Core pool and field widths
    localparam int MAX_CORES = 16;
    localparam int CNT_W     = 5;
    localparam int MASK_W    = 16;
    localparam int FIELD_W   = 24;
    localparam int RATIO_W   = 8;
    localparam int STEP_W    = 5;
    localparam int HOLD_W    = 4;
    localparam int ACT_W     = 3;

    // Q24.8 quotients and the widths of the policy arithmetic
    localparam int FRAC_W  = 8;
    localparam int Q_W     = FIELD_W + FRAC_W;
    localparam int SUM_W   = Q_W + 1;
    localparam int LEN_W   = Q_W + FRAC_W;
    localparam int PROD_W  = SUM_W + RATIO_W;
    localparam int MULT_W  = PROD_W + RATIO_W;

    // Shared divider: quotient bits retired per cycle
    localparam int DIV_BITS = 4;
    localparam int DIV_ITER = Q_W / DIV_BITS;
    localparam int ITER_W   = $clog2(DIV_ITER);

    // APB register map
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_IDLE_FILL   = 3'd0,
        REG_BURST_LEN   = 3'd1,
        REG_GROW_MANY   = 3'd2,
        REG_GROW_ONE    = 3'd3,
        REG_SHRINK      = 3'd4,
        REG_GROW_STEP   = 3'd5,
        REG_HOLD_ROUNDS = 3'd6
    } cfg_idx_t;

    localparam logic [FIELD_W-1:0] RST_IDLE_FILL   = 24'd4000;
    localparam logic [FIELD_W-1:0] RST_BURST_LEN   = 24'd1000;
    localparam logic [RATIO_W-1:0] RST_GROW_MANY   = 8'd230;
    localparam logic [RATIO_W-1:0] RST_GROW_ONE    = 8'd205;
    localparam logic [RATIO_W-1:0] RST_SHRINK      = 8'd179;
    localparam logic [STEP_W-1:0]  RST_GROW_STEP   = 5'd4;
    localparam logic [HOLD_W-1:0]  RST_HOLD_ROUNDS = 4'd3;
    localparam logic [HOLD_W-1:0]  RST_HOLD_COUNT  = 4'd1;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_SUM    = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    // Division in flight
    typedef enum logic [1:0] {
        DIV_IDLE  = 2'd0,
        DIV_LEN   = 2'd1,
        DIV_GRAIN = 2'd2
    } div_sel_t;

    // Multiply/compare step in flight
    typedef enum logic [1:0] {
        MUL_MANY = 2'd0,
        MUL_ONE  = 2'd1,
        MUL_SHR  = 2'd2,
        MUL_CNT  = 2'd3
    } mul_op_t;

    // Decision taken for a period
    typedef enum logic [ACT_W-1:0] {
        ACT_HOLD   = 3'd0,
        ACT_MAX    = 3'd1,
        ACT_STEP   = 3'd2,
        ACT_ONE    = 3'd3,
        ACT_SHRINK = 3'd4
    } action_t;

    typedef struct packed {
        logic [FIELD_W-1:0] filler_time_us;
        logic [FIELD_W-1:0] filler_switches;
        logic [FIELD_W-1:0] app_time_us;
        logic [FIELD_W-1:0] total_switches;
    } in_beat_t;

    typedef struct packed {
        logic [CNT_W-1:0]  active_cores;
        logic [MASK_W-1:0] core_mask;
        logic [ACT_W-1:0]  action;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core_count_governor.sv =====
// Core count governor top level: shared restoring divider, shared multiplier and policy.
// Depends on ccg_pkg for types, widths, register map and codes.
//
//  channel | ports                                   | moves
//  --------+-----------------------------------------+-------------------------------
//  s_      | s_valid, s_ready, s_data                | one sampling period's deltas
//  m_      | m_valid, m_ready, m_data                | core count, mask and action
//  apb     | psel, penable, pwrite, paddr, pwdata,   | policy registers, 4-byte stride
//          | prdata, pready                          |
//
// An item passes through the shared divider (three Q24.8 quotients, 4 quotient bits per
// cycle), the sum, four steps through the shared multiplier/comparator, the decision and
// an idle state in which s_ready is high together with the result.
// Reset (aresetn low, synchronous) restores the policy registers, 16 cores and a countdown of one.
// A stalled result holds in the output register; the decision waits while it is full.
`timescale 1ns / 1ps
`default_nettype none

module core_count_governor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ccg_pkg::in_beat_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ccg_pkg::out_beat_t             m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ccg_pkg::ADDR_W-1:0]     paddr,
    input  logic [ccg_pkg::DATA_W-1:0]     pwdata,
    output logic [ccg_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // Policy registers
    logic [ccg_pkg::FIELD_W-1:0] idle_fill_reg;
    logic [ccg_pkg::FIELD_W-1:0] burst_len_reg;
    logic [ccg_pkg::RATIO_W-1:0] grow_many_reg;
    logic [ccg_pkg::RATIO_W-1:0] grow_one_reg;
    logic [ccg_pkg::RATIO_W-1:0] shrink_reg;
    logic [ccg_pkg::STEP_W-1:0]  grow_step_reg;
    logic [ccg_pkg::HOLD_W-1:0]  hold_rounds_reg;

    logic                        cfg_wr;
    ccg_pkg::cfg_idx_t           cfg_idx;

    // Sequencer and governor state
    ccg_pkg::state_t             state_reg;
    ccg_pkg::state_t             state_next;
    logic [ccg_pkg::CNT_W-1:0]   core_count_reg;
    logic [ccg_pkg::CNT_W-1:0]   core_count_next;
    logic [ccg_pkg::HOLD_W-1:0]  hold_count_reg;
    logic [ccg_pkg::HOLD_W-1:0]  hold_count_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    ccg_pkg::out_beat_t          m_data_reg;
    ccg_pkg::out_beat_t          m_data_next;

    // Datapath registers
    ccg_pkg::in_beat_t           in_reg;
    ccg_pkg::div_sel_t           div_sel_reg;
    ccg_pkg::mul_op_t            mul_op_reg;
    logic [ccg_pkg::ITER_W-1:0]  iter_reg;
    logic [ccg_pkg::FIELD_W-1:0] rem_reg;
    logic [ccg_pkg::Q_W-1:0]     quo_reg;
    logic [ccg_pkg::Q_W-1:0]     idle_reg;
    logic [ccg_pkg::Q_W-1:0]     len_reg;
    logic [ccg_pkg::Q_W-1:0]     grain_reg;
    logic [ccg_pkg::SUM_W-1:0]   sum_reg;
    logic [ccg_pkg::PROD_W-1:0]  prod_reg;
    logic                        many_gt_reg;
    logic                        one_gt_reg;
    logic                        shrink_lt_reg;

    // Combinational helpers
    logic                        in_fire;
    logic                        out_free;
    logic                        decide_fire;
    logic                        div_last;
    logic [ccg_pkg::FIELD_W-1:0] div_den;
    logic [ccg_pkg::FIELD_W:0]   div_trial;
    logic [ccg_pkg::FIELD_W-1:0] div_rem;
    logic [ccg_pkg::Q_W-1:0]     div_quo;
    logic                        few_fs;
    logic                        app_idle;
    logic                        no_diff;
    logic [ccg_pkg::PROD_W-1:0]  mul_a;
    logic [ccg_pkg::RATIO_W-1:0] mul_b;
    logic [ccg_pkg::MULT_W-1:0]  mul_p;
    logic [ccg_pkg::MULT_W-1:0]  len_ext;
    logic [ccg_pkg::CNT_W-1:0]   cnt_less;
    logic                        burst;
    logic                        at_max;
    logic [ccg_pkg::CNT_W:0]     grow_sum;
    logic [ccg_pkg::CNT_W-1:0]   step_count;
    ccg_pkg::action_t            dec_action;
    logic [ccg_pkg::MASK_W:0]    mask_wide;

    localparam logic [ccg_pkg::ITER_W-1:0] ITER_LAST = ccg_pkg::ITER_W'(ccg_pkg::DIV_ITER - 1);
    localparam logic [ccg_pkg::CNT_W-1:0]  CNT_MAX   = ccg_pkg::CNT_W'(ccg_pkg::MAX_CORES);
    localparam logic [ccg_pkg::CNT_W-1:0]  CNT_ONE   = ccg_pkg::CNT_W'(1);

    assign s_ready     = (state_reg == ccg_pkg::ST_IDLE);
    assign in_fire     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign decide_fire = (state_reg == ccg_pkg::ST_DECIDE) && out_free;
    assign div_last    = (iter_reg == ITER_LAST);
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign pready      = 1'b1;

    // Decode APB writes
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = ccg_pkg::cfg_idx_t'(paddr[ccg_pkg::ADDR_W-1:2]);

    // Read back the policy registers
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            ccg_pkg::REG_IDLE_FILL:   prdata = ccg_pkg::DATA_W'(idle_fill_reg);
            ccg_pkg::REG_BURST_LEN:   prdata = ccg_pkg::DATA_W'(burst_len_reg);
            ccg_pkg::REG_GROW_MANY:   prdata = ccg_pkg::DATA_W'(grow_many_reg);
            ccg_pkg::REG_GROW_ONE:    prdata = ccg_pkg::DATA_W'(grow_one_reg);
            ccg_pkg::REG_SHRINK:      prdata = ccg_pkg::DATA_W'(shrink_reg);
            ccg_pkg::REG_GROW_STEP:   prdata = ccg_pkg::DATA_W'(grow_step_reg);
            ccg_pkg::REG_HOLD_ROUNDS: prdata = ccg_pkg::DATA_W'(hold_rounds_reg);
            default:                  prdata = '0;
        endcase
    end

    // Special cases of the period
    assign few_fs   = in_reg.filler_switches < ccg_pkg::FIELD_W'(core_count_reg);
    assign app_idle = in_reg.app_time_us <= in_reg.filler_time_us;
    assign no_diff  = in_reg.total_switches <= in_reg.filler_switches;

    // Shared restoring divider: retire DIV_BITS quotient bits; a zero divisor gives all ones
    always_comb begin
        div_den = in_reg.filler_switches;
        if (div_sel_reg == ccg_pkg::DIV_GRAIN) begin
            div_den = in_reg.total_switches - in_reg.filler_switches;
        end
        div_rem   = rem_reg;
        div_quo   = quo_reg;
        div_trial = '0;
        for (int i = 0; i < ccg_pkg::DIV_BITS; i++) begin
            div_trial = {div_rem, div_quo[ccg_pkg::Q_W-1]};
            div_quo   = {div_quo[ccg_pkg::Q_W-2:0], 1'b0};
            if (div_trial >= {1'b0, div_den}) begin
                div_rem    = ccg_pkg::FIELD_W'(div_trial - {1'b0, div_den});
                div_quo[0] = 1'b1;
            end else begin
                div_rem = div_trial[ccg_pkg::FIELD_W-1:0];
            end
        end
    end

    // Shared multiplier: ratio times sum, then shrink product times count less one
    assign cnt_less = core_count_reg - CNT_ONE;
    assign len_ext  = ccg_pkg::MULT_W'({len_reg, {ccg_pkg::FRAC_W{1'b0}}});

    always_comb begin
        mul_a = ccg_pkg::PROD_W'(sum_reg);
        mul_b = grow_many_reg;
        unique case (mul_op_reg)
            ccg_pkg::MUL_MANY: mul_b = grow_many_reg;
            ccg_pkg::MUL_ONE:  mul_b = grow_one_reg;
            ccg_pkg::MUL_SHR:  mul_b = shrink_reg;
            ccg_pkg::MUL_CNT: begin
                mul_a = prod_reg;
                mul_b = {{(ccg_pkg::RATIO_W - ccg_pkg::CNT_W){1'b0}}, cnt_less};
            end
            default:           mul_b = grow_many_reg;
        endcase
        mul_p = ccg_pkg::MULT_W'(mul_a) * ccg_pkg::MULT_W'(mul_b);
    end

    // Decide the new core count, countdown and action
    assign burst    = len_reg > {burst_len_reg, {ccg_pkg::FRAC_W{1'b0}}};
    assign at_max   = core_count_reg >= CNT_MAX;
    assign grow_sum = {1'b0, core_count_reg} + {1'b0, grow_step_reg};
    assign step_count = (grow_sum > {1'b0, CNT_MAX}) ? CNT_MAX
                                                     : grow_sum[ccg_pkg::CNT_W-1:0];

    always_comb begin
        core_count_next = core_count_reg;
        hold_count_next = hold_count_reg;
        dec_action      = ccg_pkg::ACT_HOLD;
        priority if (burst) begin
            core_count_next = CNT_MAX;
            hold_count_next = hold_rounds_reg;
            dec_action      = ccg_pkg::ACT_MAX;
        end else if (many_gt_reg && !at_max) begin
            core_count_next = step_count;
            hold_count_next = hold_rounds_reg;
            dec_action      = ccg_pkg::ACT_STEP;
        end else if (one_gt_reg && !at_max) begin
            core_count_next = core_count_reg + CNT_ONE;
            dec_action      = ccg_pkg::ACT_ONE;
        end else if (grain_reg > idle_reg) begin
            dec_action      = ccg_pkg::ACT_HOLD;
        end else if (core_count_reg > CNT_ONE && shrink_lt_reg) begin
            if (hold_count_reg == '0) begin
                core_count_next = cnt_less;
                dec_action      = ccg_pkg::ACT_SHRINK;
            end else begin
                hold_count_next = hold_count_reg - ccg_pkg::HOLD_W'(1);
            end
        end else begin
            dec_action      = ccg_pkg::ACT_HOLD;
        end
    end

    // Build the result beat; a full pool sets every mask bit
    always_comb begin
        mask_wide = ((ccg_pkg::MASK_W + 1)'(1) << core_count_next) - (ccg_pkg::MASK_W + 1)'(1);
        m_data_next.active_cores = core_count_next;
        m_data_next.action       = dec_action;
        if (core_count_next >= ccg_pkg::CNT_W'(ccg_pkg::MASK_W)) begin
            m_data_next.core_mask = '1;
        end else begin
            m_data_next.core_mask = mask_wide[ccg_pkg::MASK_W-1:0];
        end
    end

    // Sequence one item through divide, sum, multiply and decide
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ccg_pkg::ST_IDLE:   if (s_valid) state_next = ccg_pkg::ST_DIV;
            ccg_pkg::ST_DIV:    if (div_last && div_sel_reg == ccg_pkg::DIV_GRAIN) begin
                                    state_next = ccg_pkg::ST_SUM;
                                end
            ccg_pkg::ST_SUM:    state_next = ccg_pkg::ST_MUL;
            ccg_pkg::ST_MUL:    if (mul_op_reg == ccg_pkg::MUL_CNT) state_next = ccg_pkg::ST_DECIDE;
            ccg_pkg::ST_DECIDE: if (out_free) state_next = ccg_pkg::ST_IDLE;
            default:            state_next = ccg_pkg::ST_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (decide_fire) begin
            m_valid_next = 1'b1;
        end
    end

    // Control state and policy registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ccg_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            core_count_reg  <= CNT_MAX;
            hold_count_reg  <= ccg_pkg::RST_HOLD_COUNT;
            idle_fill_reg   <= ccg_pkg::RST_IDLE_FILL;
            burst_len_reg   <= ccg_pkg::RST_BURST_LEN;
            grow_many_reg   <= ccg_pkg::RST_GROW_MANY;
            grow_one_reg    <= ccg_pkg::RST_GROW_ONE;
            shrink_reg      <= ccg_pkg::RST_SHRINK;
            grow_step_reg   <= ccg_pkg::RST_GROW_STEP;
            hold_rounds_reg <= ccg_pkg::RST_HOLD_ROUNDS;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (decide_fire) begin
                core_count_reg <= core_count_next;
                hold_count_reg <= hold_count_next;
            end
            if (cfg_wr) begin
                unique case (cfg_idx)
                    ccg_pkg::REG_IDLE_FILL:   idle_fill_reg   <= pwdata[ccg_pkg::FIELD_W-1:0];
                    ccg_pkg::REG_BURST_LEN:   burst_len_reg   <= pwdata[ccg_pkg::FIELD_W-1:0];
                    ccg_pkg::REG_GROW_MANY:   grow_many_reg   <= pwdata[ccg_pkg::RATIO_W-1:0];
                    ccg_pkg::REG_GROW_ONE:    grow_one_reg    <= pwdata[ccg_pkg::RATIO_W-1:0];
                    ccg_pkg::REG_SHRINK:      shrink_reg      <= pwdata[ccg_pkg::RATIO_W-1:0];
                    ccg_pkg::REG_GROW_STEP:   grow_step_reg   <= pwdata[ccg_pkg::STEP_W-1:0];
                    ccg_pkg::REG_HOLD_ROUNDS: hold_rounds_reg <= pwdata[ccg_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // Capture the beat and start the idle grain division
        if (in_fire) begin
            in_reg      <= s_data;
            div_sel_reg <= ccg_pkg::DIV_IDLE;
            iter_reg    <= '0;
            rem_reg     <= '0;
            quo_reg     <= {s_data.filler_time_us, {ccg_pkg::FRAC_W{1'b0}}};
        end

        // Advance the divider; store each quotient with its special cases applied
        if (state_reg == ccg_pkg::ST_DIV) begin
            iter_reg <= iter_reg + ccg_pkg::ITER_W'(1);
            if (div_last) begin
                rem_reg <= '0;
                quo_reg <= {in_reg.app_time_us, {ccg_pkg::FRAC_W{1'b0}}};
                unique case (div_sel_reg)
                    ccg_pkg::DIV_IDLE: begin
                        idle_reg    <= few_fs ? {idle_fill_reg, {ccg_pkg::FRAC_W{1'b0}}}
                                          : div_quo;
                        div_sel_reg <= ccg_pkg::DIV_LEN;
                    end
                    ccg_pkg::DIV_LEN: begin
                        len_reg     <= app_idle ? '0 : div_quo;
                        div_sel_reg <= ccg_pkg::DIV_GRAIN;
                    end
                    ccg_pkg::DIV_GRAIN: begin
                        priority if (app_idle) begin
                            grain_reg <= '0;
                        end else if (no_diff) begin
                            grain_reg <= '1;
                        end else begin
                            grain_reg <= div_quo;
                        end
                    end
                    default: ;
                endcase
            end else begin
                rem_reg <= div_rem;
                quo_reg <= div_quo;
            end
        end

        // Form compute length plus idle grain
        if (state_reg == ccg_pkg::ST_SUM) begin
            sum_reg    <= ccg_pkg::SUM_W'(len_reg) + ccg_pkg::SUM_W'(idle_reg);
            mul_op_reg <= ccg_pkg::MUL_MANY;
        end

        // Step the multiplier through the three ratio tests
        if (state_reg == ccg_pkg::ST_MUL) begin
            unique case (mul_op_reg)
                ccg_pkg::MUL_MANY: begin
                    many_gt_reg <= len_ext > mul_p;
                    mul_op_reg  <= ccg_pkg::MUL_ONE;
                end
                ccg_pkg::MUL_ONE: begin
                    one_gt_reg <= len_ext > mul_p;
                    mul_op_reg <= ccg_pkg::MUL_SHR;
                end
                ccg_pkg::MUL_SHR: begin
                    prod_reg   <= mul_p[ccg_pkg::PROD_W-1:0];
                    mul_op_reg <= ccg_pkg::MUL_CNT;
                end
                ccg_pkg::MUL_CNT: begin
                    shrink_lt_reg <= len_ext < mul_p;
                end
                default: ;
            endcase
        end

        // Load the result beat
        if (decide_fire) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ccg_chk.sv =====
// Port checker for the core count governor, bound to the top level.
// Depends on ccg_pkg for beat types, the core limit and action codes.
`timescale 1ns / 1ps
`default_nettype none

module ccg_chk (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire ccg_pkg::out_beat_t m_data
);

    // Busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on back-to-back cycles");

    // Count stays between one and the pool size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active_cores >= ccg_pkg::CNT_W'(1)) &&
                    (m_data.active_cores <= ccg_pkg::CNT_W'(ccg_pkg::MAX_CORES)))
        else $error("active core count out of range");

    // Mask covers exactly the active cores
    a_mask_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (ccg_pkg::MASK_W + 1)'(m_data.core_mask) ==
                    ((ccg_pkg::MASK_W + 1)'(1) << m_data.active_cores)
                    - (ccg_pkg::MASK_W + 1)'(1))
        else $error("core mask does not match active count");

    // Only defined actions leave the block
    a_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.action <= ccg_pkg::ACT_SHRINK)
        else $error("undefined action code");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind core_count_governor ccg_chk u_ccg_chk (.*);

`default_nettype wire
